/* hw/rtl/tea_pkg.sv */
// Shared types and constants for the TEA block cipher pipeline.
`default_nettype none

package tea_pkg;

   localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

   localparam int CSR_ADDR_WIDTH = 4;

   // Register index codes (byte address bits 3:2)
   localparam logic [1:0] CSR_KEY_WORD0 = 2'd0;
   localparam logic [1:0] CSR_KEY_WORD1 = 2'd1;
   localparam logic [1:0] CSR_KEY_WORD2 = 2'd2;
   localparam logic [1:0] CSR_KEY_WORD3 = 2'd3;

   localparam logic [31:0] KEY_WORD0_RESET = 32'h30f6fe55;
   localparam logic [31:0] KEY_WORD1_RESET = 32'hc10bbf62;
   localparam logic [31:0] KEY_WORD2_RESET = 32'h347cb3c9;
   localparam logic [31:0] KEY_WORD3_RESET = 32'hfb293e97;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } tea_key_type;

   typedef struct packed {
      logic        decrypt;
      logic [31:0] v0;
      logic [31:0] v1;
   } tea_item_type;

endpackage

`default_nettype wire

/* hw/rtl/tea_csr.sv */
// Key register file behind the APB-style configuration port.
`default_nettype none

module tea_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tea_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready,
   output tea_pkg::tea_key_type                    key
);
   import tea_pkg::*;

   tea_key_type key_ff;
   tea_key_type key_in;
   logic [1:0]  index;
   logic        write_en;

   assign index      = csr_paddr[3:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign key        = key_ff;

   always_comb begin
      key_in = key_ff;
      if (write_en) begin
         unique case (index)
            CSR_KEY_WORD0: key_in.word0 = csr_pwdata;
            CSR_KEY_WORD1: key_in.word1 = csr_pwdata;
            CSR_KEY_WORD2: key_in.word2 = csr_pwdata;
            CSR_KEY_WORD3: key_in.word3 = csr_pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_KEY_WORD0: csr_prdata = key_ff.word0;
         CSR_KEY_WORD1: csr_prdata = key_ff.word1;
         CSR_KEY_WORD2: csr_prdata = key_ff.word2;
         CSR_KEY_WORD3: csr_prdata = key_ff.word3;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.word0 <= KEY_WORD0_RESET;
         key_ff.word1 <= KEY_WORD1_RESET;
         key_ff.word2 <= KEY_WORD2_RESET;
         key_ff.word3 <= KEY_WORD3_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/tea_round_stage.sv */
// One half-round of TEA followed by its pipeline register.
`default_nettype none

module tea_round_stage #(
   parameter logic [31:0] SUM_ENC = 32'h0,
   parameter logic [31:0] SUM_DEC = 32'h0,
   parameter bit          SECOND  = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  in_valid,
   input  wire tea_pkg::tea_item_type in_item,
   input  wire tea_pkg::tea_key_type  key,
   output logic                       out_valid,
   output tea_pkg::tea_item_type      out_item
);
   import tea_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   tea_item_type item_ff;
   tea_item_type item_in;

   logic         upd_v0;
   logic [31:0]  src;
   logic [31:0]  dst;
   logic [31:0]  sum;
   logic [31:0]  ka;
   logic [31:0]  kb;
   logic [31:0]  term_a;
   logic [31:0]  term_b;
   logic [31:0]  term_c;
   logic [31:0]  mix;
   logic [31:0]  dst_new;

   // Encrypt updates v0 first, decrypt undoes v1 first.
   assign upd_v0 = (SECOND == in_item.decrypt);
   assign src    = upd_v0 ? in_item.v1 : in_item.v0;
   assign dst    = upd_v0 ? in_item.v0 : in_item.v1;
   assign ka     = upd_v0 ? key.word0 : key.word2;
   assign kb     = upd_v0 ? key.word1 : key.word3;
   assign sum    = in_item.decrypt ? SUM_DEC : SUM_ENC;

   assign term_a  = (src << 4) + ka;
   assign term_b  = src + sum;
   assign term_c  = (src >> 5) + kb;
   assign mix     = term_a ^ term_b ^ term_c;
   assign dst_new = in_item.decrypt ? (dst - mix) : (dst + mix);

   always_comb begin
      item_in = item_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in        = in_valid;
         item_in.decrypt = in_item.decrypt;
         item_in.v0      = upd_v0 ? dst_new : in_item.v0;
         item_in.v1      = upd_v0 ? in_item.v1 : dst_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

/* hw/rtl/tea_block_cipher.sv */
// TEA block cipher top level: key registers and the unrolled half-round pipeline.
// Pipeline: one stage per half-round; rsp_valid and the result come from the last stage register.
// Throughput: one item per cycle; the whole pipeline holds while the output item is stalled.
// Reset: synchronous, active high; clears all stage valid bits and loads the default key.
// Items already in flight when reset is asserted are dropped.
`default_nettype none

module tea_block_cipher #(
   parameter int ROUNDS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_operation,
   input  wire logic [31:0]                        req_block_low,
   input  wire logic [31:0]                        req_block_high,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [31:0]                             rsp_result_low,
   output logic [31:0]                             rsp_result_high,
   // configuration port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tea_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   import tea_pkg::*;

   // Two stages per round: first and second half of the Feistel round.
   localparam int STAGES = 2 * ROUNDS;

   tea_key_type  key;
   tea_item_type req_item;
   logic         advance;

   logic         stage_valid [0:STAGES-1];
   tea_item_type stage_item  [0:STAGES-1];

   // The key must only be rewritten while the pipeline is empty (the block does not
   // enforce this), so every stage reads the live key registers directly.
   tea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   assign req_item.decrypt = req_operation;
   assign req_item.v0      = req_block_low;
   assign req_item.v1      = req_block_high;

   // Advance every stage unless the finished item at the end is held back.
   // An empty output slot lets the pipeline move even while rsp_stall is high.
   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      // Round sums: encrypt uses delta*(r+1), decrypt walks down from delta*ROUNDS.
      localparam logic [63:0] SUM_ENC_W = 64'(TEA_DELTA) * 64'(k / 2 + 1);
      localparam logic [63:0] SUM_DEC_W = 64'(TEA_DELTA) * 64'(ROUNDS - k / 2);

      logic         in_valid;
      tea_item_type in_item;

      if (k == 0) begin : g_head
         assign in_valid = req_valid;
         assign in_item  = req_item;
      end else begin : g_link
         assign in_valid = stage_valid[k-1];
         assign in_item  = stage_item[k-1];
      end

      tea_round_stage #(
         .SUM_ENC (SUM_ENC_W[31:0]),
         .SUM_DEC (SUM_DEC_W[31:0]),
         .SECOND  (1'(k % 2))
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (in_valid),
         .in_item   (in_item),
         .key       (key),
         .out_valid (stage_valid[k]),
         .out_item  (stage_item[k])
      );
   end

   // The last stage register doubles as the output register.
   assign rsp_valid       = stage_valid[STAGES-1];
   assign rsp_result_low  = stage_item[STAGES-1].v0;
   assign rsp_result_high = stage_item[STAGES-1].v1;

   // An item in the next-to-last stage reaches the output on an advancing edge.
   a_tail_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_valid[STAGES-2]) |=> rsp_valid)
      else $error("item lost between the last two stages");

   // A held output keeps its valid bit.
   a_hold_keeps: assert property (@(posedge clock) disable iff (reset)
      !advance |=> rsp_valid)
      else $error("stalled output item dropped");

   // Reset empties the pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A key write reads back on the following cycle at the same address.
   a_key_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |=>
         ((csr_prdata == $past(csr_pwdata)) || (csr_paddr != $past(csr_paddr))))
      else $error("key register readback mismatch");

endmodule

`default_nettype wire
